// ===== rtl/ttc_pkg.sv =====
package ttc_pkg;

   // number of edges of a triangle
   localparam int EDGE_COUNT = 3;

   // coverage mask width on the result port, fixed for tiles up to 4x4
   localparam int MASK_BITS = 16;

   typedef logic [MASK_BITS-1:0] mask_type;

endpackage

// ===== rtl/ttc_edge_setup.sv =====
module ttc_edge_setup
   import ttc_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic signed [COORD_BITS-1:0]   start_x,
   input  logic signed [COORD_BITS-1:0]   start_y,
   input  logic signed [COORD_BITS-1:0]   end_x,
   input  logic signed [COORD_BITS-1:0]   end_y,
   input  logic        [COORD_BITS-2:0]   origin_x,
   input  logic        [COORD_BITS-2:0]   origin_y,
   output logic signed [COORD_BITS:0]     edge_a,
   output logic signed [COORD_BITS:0]     edge_b,
   output logic signed [2*COORD_BITS+3:0] edge_w
);

   localparam int AW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS;
   localparam int TW = 2 * COORD_BITS + 1;
   localparam int EW = 2 * COORD_BITS + 4;

   logic signed [AW-1:0] start_x_ext;
   logic signed [AW-1:0] start_y_ext;
   logic signed [AW-1:0] end_x_ext;
   logic signed [AW-1:0] end_y_ext;
   logic signed [COORD_BITS-1:0] origin_x_s;
   logic signed [COORD_BITS-1:0] origin_y_s;
   logic signed [PW-1:0] cross_p;
   logic signed [PW-1:0] cross_q;
   logic signed [TW-1:0] term_a;
   logic signed [TW-1:0] term_b;
   logic signed [EW-1:0] cross_p_ext;
   logic signed [EW-1:0] cross_q_ext;
   logic signed [EW-1:0] term_a_ext;
   logic signed [EW-1:0] term_b_ext;

   // sign extension of the vertex coordinates, origin is non-negative
   assign start_x_ext = AW'(start_x);
   assign start_y_ext = AW'(start_y);
   assign end_x_ext   = AW'(end_x);
   assign end_y_ext   = AW'(end_y);
   assign origin_x_s  = $signed({1'b0, origin_x});
   assign origin_y_s  = $signed({1'b0, origin_y});

   // edge coefficients a = yi - yj, b = xj - xi
   assign edge_a = start_y_ext - end_y_ext;
   assign edge_b = end_x_ext - start_x_ext;

   // one rank of multipliers: constant term and origin terms in parallel
   assign cross_p = PW'(start_x) * PW'(end_y);
   assign cross_q = PW'(start_y) * PW'(end_x);
   assign term_a  = TW'(edge_a) * TW'(origin_x_s);
   assign term_b  = TW'(edge_b) * TW'(origin_y_s);

   // edge value at the tile origin
   assign cross_p_ext = EW'(cross_p);
   assign cross_q_ext = EW'(cross_q);
   assign term_a_ext  = EW'(term_a);
   assign term_b_ext  = EW'(term_b);
   assign edge_w = term_a_ext + term_b_ext + cross_p_ext - cross_q_ext;

endmodule

// ===== rtl/ttc_tile_test.sv =====
module ttc_tile_test
   import ttc_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int TILE_DIM   = 4
) (
   input  logic signed [COORD_BITS:0]     edge_a [EDGE_COUNT],
   input  logic signed [COORD_BITS:0]     edge_b [EDGE_COUNT],
   input  logic signed [2*COORD_BITS+3:0] edge_w [EDGE_COUNT],
   output mask_type                       coverage_mask,
   output logic                           tile_rejected
);

   localparam int EW = 2 * COORD_BITS + 4;
   localparam logic signed [EW-1:0] TILE_EXT = EW'(TILE_DIM);

   logic signed [EW-1:0] a_ext [EDGE_COUNT];
   logic signed [EW-1:0] b_ext [EDGE_COUNT];
   logic signed [EW-1:0] bound [EDGE_COUNT];
   logic [EDGE_COUNT-1:0] edge_out;
   mask_type              mask_raw;

   // conservative cull distance per edge: -TILE * max(0, a, b, a+b)
   always_comb begin
      logic signed [EW-1:0] lim;
      lim = '0;
      for (int e = 0; e < EDGE_COUNT; e++) begin
         a_ext[e] = EW'(edge_a[e]);
         b_ext[e] = EW'(edge_b[e]);
         lim = '0;
         if (a_ext[e] > lim) begin
            lim = a_ext[e];
         end
         if (b_ext[e] > lim) begin
            lim = b_ext[e];
         end
         if (a_ext[e] + b_ext[e] > lim) begin
            lim = a_ext[e] + b_ext[e];
         end
         bound[e]    = -(TILE_EXT * lim);
         edge_out[e] = edge_w[e] < bound[e];
      end
   end

   // per-pixel inside test, all three stepped edge values non-negative
   always_comb begin
      logic signed [EW-1:0] step_sum;
      logic                 pixel_in;
      step_sum = '0;
      pixel_in = 1'b0;
      mask_raw = '0;
      for (int y = 0; y < TILE_DIM; y++) begin
         for (int x = 0; x < TILE_DIM; x++) begin
            pixel_in = 1'b1;
            for (int e = 0; e < EDGE_COUNT; e++) begin
               step_sum = edge_w[e] + a_ext[e] * EW'(x) + b_ext[e] * EW'(y);
               if (step_sum[EW-1]) begin
                  pixel_in = 1'b0;
               end
            end
            mask_raw[x + y * TILE_DIM] = pixel_in;
         end
      end
   end

   assign tile_rejected = |edge_out;
   assign coverage_mask = tile_rejected ? '0 : mask_raw;

endmodule

// ===== rtl/triangle_tile_coverage_top.sv =====
// Triangle tile coverage test for one square tile of TILE_DIM x TILE_DIM pixels.
// Request channel: drive the three vertices and the tile origin on the req_
// ports and raise start; the transaction is taken at a rising edge where start
// is high and busy is low. busy is low in normal operation, so one transaction
// is taken every clock cycle in which start is high.
// Response channel: rsp_valid is high for exactly one cycle with
// rsp_coverage_mask and rsp_tile_rejected; the receiver cannot hold it off.
// Pipeline: the response reaches the rsp_ ports through the input register, the
// edge setup register and the result register, in that order. Throughput is one
// transaction per cycle while busy is low; the edge setup multipliers and the
// per-pixel adders each sit between one pair of registers.
// Reset: synchronous, active high; it clears the pipeline valid bits, and busy
// stays high for the cycle after reset. Transactions in flight are dropped.
// Bit x + y*TILE_DIM of the mask is pixel (x, y); bits at and above
// TILE_DIM*TILE_DIM are zero, and the mask is zero when the tile is rejected.
module triangle_tile_coverage_top
   import ttc_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int TILE_DIM   = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_vertex0_x,
   input  logic signed [COORD_BITS-1:0] req_vertex0_y,
   input  logic signed [COORD_BITS-1:0] req_vertex1_x,
   input  logic signed [COORD_BITS-1:0] req_vertex1_y,
   input  logic signed [COORD_BITS-1:0] req_vertex2_x,
   input  logic signed [COORD_BITS-1:0] req_vertex2_y,
   input  logic        [COORD_BITS-2:0] req_tile_origin_x,
   input  logic        [COORD_BITS-2:0] req_tile_origin_y,
   output logic                         rsp_valid,
   output mask_type                     rsp_coverage_mask,
   output logic                         rsp_tile_rejected
);

   localparam int AW = COORD_BITS + 1;
   localparam int EW = 2 * COORD_BITS + 4;

   logic req_accept;
   logic busy_ff;

   // input register
   logic                         in_valid_ff;
   logic signed [COORD_BITS-1:0] vx_ff [EDGE_COUNT];
   logic signed [COORD_BITS-1:0] vy_ff [EDGE_COUNT];
   logic        [COORD_BITS-2:0] ox_ff;
   logic        [COORD_BITS-2:0] oy_ff;

   // edge setup register
   logic              edge_valid_ff;
   logic signed [AW-1:0] a_in [EDGE_COUNT];
   logic signed [AW-1:0] b_in [EDGE_COUNT];
   logic signed [EW-1:0] w_in [EDGE_COUNT];
   logic signed [AW-1:0] a_ff [EDGE_COUNT];
   logic signed [AW-1:0] b_ff [EDGE_COUNT];
   logic signed [EW-1:0] w_ff [EDGE_COUNT];

   // result register
   logic     rsp_valid_ff;
   mask_type mask_in;
   logic     rejected_in;
   mask_type mask_ff;
   logic     rejected_ff;

   assign busy       = busy_ff;
   assign req_accept = start && !busy_ff;

   // control: busy and pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         in_valid_ff   <= 1'b0;
         edge_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         in_valid_ff   <= req_accept;
         edge_valid_ff <= in_valid_ff;
         rsp_valid_ff  <= edge_valid_ff;
      end
   end

   // capture the request transaction
   always_ff @(posedge clock) begin
      if (req_accept) begin
         vx_ff[0] <= req_vertex0_x;
         vy_ff[0] <= req_vertex0_y;
         vx_ff[1] <= req_vertex1_x;
         vy_ff[1] <= req_vertex1_y;
         vx_ff[2] <= req_vertex2_x;
         vy_ff[2] <= req_vertex2_y;
         ox_ff    <= req_tile_origin_x;
         oy_ff    <= req_tile_origin_y;
      end
   end

   // edge e runs from vertex e+1 to vertex e+2, indices modulo three
   for (genvar e = 0; e < EDGE_COUNT; e++) begin : g_edge
      ttc_edge_setup #(
         .COORD_BITS (COORD_BITS)
      ) u_edge_setup (
         .start_x  (vx_ff[(e + 1) % EDGE_COUNT]),
         .start_y  (vy_ff[(e + 1) % EDGE_COUNT]),
         .end_x    (vx_ff[(e + 2) % EDGE_COUNT]),
         .end_y    (vy_ff[(e + 2) % EDGE_COUNT]),
         .origin_x (ox_ff),
         .origin_y (oy_ff),
         .edge_a   (a_in[e]),
         .edge_b   (b_in[e]),
         .edge_w   (w_in[e])
      );
   end

   // edge coefficients and origin values
   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         a_ff <= a_in;
         b_ff <= b_in;
         w_ff <= w_in;
      end
   end

   ttc_tile_test #(
      .COORD_BITS (COORD_BITS),
      .TILE_DIM   (TILE_DIM)
   ) u_tile_test (
      .edge_a        (a_ff),
      .edge_b        (b_ff),
      .edge_w        (w_ff),
      .coverage_mask (mask_in),
      .tile_rejected (rejected_in)
   );

   // response payload
   always_ff @(posedge clock) begin
      if (edge_valid_ff) begin
         mask_ff     <= mask_in;
         rejected_ff <= rejected_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_coverage_mask = mask_ff;
   assign rsp_tile_rejected = rejected_ff;

   // a rejected tile never reports covered pixels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_coverage_mask == '0 || !rsp_tile_rejected))
      else $error("rejected tile with non-zero coverage mask");

   // each taken transaction gives exactly one response on rsp_valid
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
         |-> (rsp_valid == $past(req_accept, 3)))
      else $error("response strobe does not match taken transaction");

   // the edges close the triangle: a and b each sum to zero
   assert property (@(posedge clock) disable iff (reset)
      edge_valid_ff |->
         ((AW + 2)'(a_ff[0]) + (AW + 2)'(a_ff[1]) + (AW + 2)'(a_ff[2]) == '0 &&
          (AW + 2)'(b_ff[0]) + (AW + 2)'(b_ff[1]) + (AW + 2)'(b_ff[2]) == '0))
      else $error("edge coefficients do not close the triangle");

endmodule
